FILE: sv/heart_rate_measurement_parser_assert.svh
// Assertion macros for the heart-rate measurement parser.
// Included by the top level; no other dependencies.
`ifndef HEART_RATE_MEASUREMENT_PARSER_ASSERT_SVH
`define HEART_RATE_MEASUREMENT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HRMP_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HRMP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hrmp_pkg.sv
// Shared constants, codes and record type of the heart-rate measurement parser.
// No dependencies.
package hrmp_pkg;

  localparam int MAX_PACKET_BYTES = 20;
  localparam int MAX_RR_INTERVALS = 10;

  localparam int POS_W       = $clog2(MAX_PACKET_BYTES + 1);
  localparam int RR_W        = $clog2(MAX_RR_INTERVALS + 1);
  localparam int COUNT_OUT_W = 4;
  localparam int FLAG_W      = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // flags byte bit positions
  localparam int FLAG_HR16        = 0;
  localparam int FLAG_CONTACT     = 1;
  localparam int FLAG_CONTACT_SUP = 2;
  localparam int FLAG_ENERGY      = 3;
  localparam int FLAG_RR          = 4;

  typedef enum logic [1:0] {
    KIND_HEART_RATE = 2'd0,
    KIND_ENERGY     = 2'd1,
    KIND_RR         = 2'd2,
    KIND_END        = 2'd3
  } field_kind_t;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'd0,
    PH_HR_LO = 3'd1,
    PH_HR_HI = 3'd2,
    PH_EN_LO = 3'd3,
    PH_EN_HI = 3'd4,
    PH_RR_LO = 3'd5,
    PH_RR_HI = 3'd6,
    PH_SKIP  = 3'd7
  } phase_t;

  // one parsed result on its way from the parser to the output stage
  typedef struct packed {
    field_kind_t               kind;
    logic [15:0]               value;
    logic [COUNT_OUT_W-1:0]    slot;
    logic                      contact_sup;
    logic                      contact_stat;
    logic                      done;
    logic [COUNT_OUT_W-1:0]    rr_total;
    logic                      ignored;
  } hrmp_rec_t;

endpackage

FILE: sv/hrmp_in_if.sv
// Byte channel into the heart-rate measurement parser.
// No dependencies.
interface hrmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

FILE: sv/hrmp_out_if.sv
// Result channel out of the heart-rate measurement parser.
// No dependencies.
interface hrmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  field_kind;
  logic [15:0] field_value;
  logic [3:0]  rr_slot;
  logic        contact_supported;
  logic        contact_detected;
  logic        packet_done;
  logic [3:0]  rr_total;
  logic        packet_ignored;

  modport source (
    output valid, output field_kind, output field_value, output rr_slot,
    output contact_supported, output contact_detected, output packet_done,
    output rr_total, output packet_ignored, input ready
  );
  modport sink (
    input valid, input field_kind, input field_value, input rr_slot,
    input contact_supported, input contact_detected, input packet_done,
    input rr_total, input packet_ignored, output ready
  );
endinterface

FILE: sv/heart_rate_measurement_parser.sv
// Top level of the heart-rate measurement parser.
// Depends on hrmp_pkg, hrmp_in_if, hrmp_out_if, hrmp_front, hrmp_queue, hrmp_back
// and the assertion macros in heart_rate_measurement_parser_assert.svh.

// Parses heart-rate measurement notifications one byte per transaction,
// flags byte first, last byte marked by packet_end. Each completed field
// (heart rate, energy expended, RR interval) leaves as one result
// transaction; a packet's last byte always yields a result, an end-only
// record (kind 3) when it completes no field, with packet_ignored set for a
// flags-only packet. RR intervals stay raw in 1/1024 s units. Bytes past the
// first 20 of a packet, past ten RR intervals, and unfinished fields are
// dropped. Rate: one byte per clock cycle while the record queue has room,
// set by the single parse phase register of the front end; each result is
// held in the record queue and then in the output register. Input ready
// falls only when the two-entry record queue is full, i.e. the result side
// has stalled for a while; no setup or clearing pass is needed after reset.

`include "heart_rate_measurement_parser_assert.svh"

module heart_rate_measurement_parser
  import hrmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hrmp_in_if.sink    meas_in,
  hrmp_out_if.source meas_out
);

  // front end -> queue
  logic      f_push;
  logic      f_ready;
  hrmp_rec_t f_rec;

  // queue -> output stage
  logic      b_valid;
  logic      b_pop;
  hrmp_rec_t b_rec;

  // Byte parser: phase machine, flags, byte position and RR count.
  hrmp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .meas_in (meas_in),
    .q_ready (f_ready),
    .q_push  (f_push),
    .q_rec   (f_rec)
  );

  // Decouples parsing from the result handshake.
  hrmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_rec   (f_rec),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_rec    (b_rec),
    .pop        (b_pop)
  );

  // Registered result stage; takes a new record whenever the slot frees.
  hrmp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_rec    (b_rec),
    .q_pop    (b_pop),
    .meas_out (meas_out)
  );

  // A closing byte always leaves a record behind in the queue.
  `HRMP_ASSERT_NEXT(a_end_queued, clk, rst, meas_in.valid && meas_in.ready && meas_in.packet_end, b_valid, "packet end produced no queued record")

  // Flags-only packets report an end record with contact bits cleared.
  `HRMP_ASSERT_IMPLY(a_ignored_form, clk, rst, meas_out.valid && meas_out.packet_ignored, meas_out.field_kind == KIND_END && !meas_out.contact_supported && !meas_out.contact_detected, "malformed ignored-packet result")

  // End-only records come only with the packet's last byte.
  `HRMP_ASSERT_IMPLY(a_end_kind_done, clk, rst, meas_out.valid && meas_out.field_kind == KIND_END, meas_out.packet_done, "end record without packet_done")

  // Contact status is only reported when contact is supported.
  `HRMP_ASSERT_IMPLY(a_contact_dep, clk, rst, meas_out.valid && meas_out.contact_detected, meas_out.contact_supported, "contact detected without support")

endmodule

FILE: sv/hrmp_front.sv
// Parser front end: takes notification bytes and runs the parse phase machine.
// Depends on hrmp_pkg and hrmp_in_if.
module hrmp_front
  import hrmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hrmp_in_if.sink     meas_in,
  input  logic        q_ready,
  output logic        q_push,
  output hrmp_rec_t   q_rec
);

  phase_t            phase, phase_next;
  logic [FLAG_W-1:0] flag_bits, flag_bits_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        low_byte_hold, low_byte_hold_next;
  logic [RR_W-1:0]   rr_count, rr_count_next;

  logic              accept;
  logic              pos_ok;
  logic              emit;
  field_kind_t       kind;
  logic [15:0]       value;
  logic [RR_W-1:0]   rr_inc;
  phase_t            after_energy;
  phase_t            after_rate;

  assign meas_in.ready = q_ready;
  assign accept        = meas_in.valid && q_ready;

  always_comb begin
    phase_next         = phase;
    flag_bits_next     = flag_bits;
    byte_position_next = byte_position;
    low_byte_hold_next = low_byte_hold;
    rr_count_next      = rr_count;
    emit               = 1'b0;
    kind               = KIND_END;
    value              = '0;
    rr_inc             = rr_count + RR_W'(1);
    after_energy       = flag_bits[FLAG_RR] ? PH_RR_LO : PH_SKIP;
    after_rate         = flag_bits[FLAG_ENERGY] ? PH_EN_LO : after_energy;
    pos_ok             = byte_position < POS_W'(MAX_PACKET_BYTES);

    if (pos_ok) begin
      byte_position_next = byte_position + POS_W'(1);
      unique case (phase)
        PH_FLAGS: begin
          flag_bits_next = meas_in.data_byte[FLAG_W-1:0];
          phase_next     = PH_HR_LO;
        end
        PH_HR_LO: begin
          if (flag_bits[FLAG_HR16]) begin
            low_byte_hold_next = meas_in.data_byte;
            phase_next         = PH_HR_HI;
          end else begin
            emit       = 1'b1;
            kind       = KIND_HEART_RATE;
            value      = {8'h00, meas_in.data_byte};
            phase_next = after_rate;
          end
        end
        PH_HR_HI: begin
          emit       = 1'b1;
          kind       = KIND_HEART_RATE;
          value      = {meas_in.data_byte, low_byte_hold};
          phase_next = after_rate;
        end
        PH_EN_LO: begin
          low_byte_hold_next = meas_in.data_byte;
          phase_next         = PH_EN_HI;
        end
        PH_EN_HI: begin
          emit       = 1'b1;
          kind       = KIND_ENERGY;
          value      = {meas_in.data_byte, low_byte_hold};
          phase_next = after_energy;
        end
        PH_RR_LO: begin
          low_byte_hold_next = meas_in.data_byte;
          phase_next         = PH_RR_HI;
        end
        PH_RR_HI: begin
          emit          = 1'b1;
          kind          = KIND_RR;
          value         = {meas_in.data_byte, low_byte_hold};
          rr_count_next = rr_inc;
          phase_next    = (rr_inc >= RR_W'(MAX_RR_INTERVALS)) ? PH_SKIP : PH_RR_LO;
        end
        PH_SKIP: begin
        end
      endcase
    end

    q_push             = accept && (emit || meas_in.packet_end);
    q_rec.kind         = kind;
    q_rec.value        = value;
    q_rec.slot         = (kind == KIND_RR) ? COUNT_OUT_W'(rr_count) : '0;
    q_rec.contact_sup  = flag_bits_next[FLAG_CONTACT_SUP];
    q_rec.contact_stat = flag_bits_next[FLAG_CONTACT];
    q_rec.done         = meas_in.packet_end;
    q_rec.rr_total     = COUNT_OUT_W'(rr_count_next);
    q_rec.ignored      = meas_in.packet_end && (byte_position_next == POS_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FLAGS;
      flag_bits     <= '0;
      byte_position <= '0;
      low_byte_hold <= '0;
      rr_count      <= '0;
    end else if (accept) begin
      if (meas_in.packet_end) begin
        // packet closed: back to the reset state for the next one
        phase         <= PH_FLAGS;
        flag_bits     <= '0;
        byte_position <= '0;
        low_byte_hold <= '0;
        rr_count      <= '0;
      end else begin
        phase         <= phase_next;
        flag_bits     <= flag_bits_next;
        byte_position <= byte_position_next;
        low_byte_hold <= low_byte_hold_next;
        rr_count      <= rr_count_next;
      end
    end
  end

endmodule

FILE: sv/hrmp_queue.sv
// Short register queue of parsed records between parser and output stage.
// Depends on hrmp_pkg.
module hrmp_queue
  import hrmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hrmp_rec_t push_rec,
  output logic      push_ready,
  output logic      pop_valid,
  output hrmp_rec_t pop_rec,
  input  logic      pop
);

  hrmp_rec_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_ok, pop_ok;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_rec    = slots[rd_ptr];
  assign push_ok    = push && push_ready;
  assign pop_ok     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/hrmp_back.sv
// Output stage: formats queued records and holds them on the result channel.
// Depends on hrmp_pkg and hrmp_out_if.
module hrmp_back
  import hrmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  hrmp_rec_t  q_rec,
  output logic       q_pop,
  hrmp_out_if.source meas_out
);

  logic                   out_valid;
  field_kind_t            kind;
  logic [15:0]            value;
  logic [COUNT_OUT_W-1:0] slot;
  logic                   sup;
  logic                   det;
  logic                   done;
  logic [COUNT_OUT_W-1:0] rr_total;
  logic                   ignored;
  logic                   take;
  logic                   sup_next;

  assign take     = q_valid && (!out_valid || meas_out.ready);
  assign q_pop    = take;
  // contact bits are suppressed on a flags-only packet
  assign sup_next = q_rec.contact_sup && !q_rec.ignored;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (meas_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind     <= q_rec.kind;
      value    <= q_rec.value;
      slot     <= q_rec.slot;
      sup      <= sup_next;
      det      <= sup_next && q_rec.contact_stat;
      done     <= q_rec.done;
      rr_total <= q_rec.rr_total;
      ignored  <= q_rec.ignored;
    end
  end

  assign meas_out.valid             = out_valid;
  assign meas_out.field_kind        = kind;
  assign meas_out.field_value       = value;
  assign meas_out.rr_slot           = slot;
  assign meas_out.contact_supported = sup;
  assign meas_out.contact_detected  = det;
  assign meas_out.packet_done       = done;
  assign meas_out.rr_total          = rr_total;
  assign meas_out.packet_ignored    = ignored;

endmodule

FILE: tb/heart_rate_measurement_parser_tb.sv
// Testbench for the heart-rate measurement parser: directed and random notifications,
// random idle on both channels, results checked against an in-bench field predictor.
// Depends on hrmp_pkg, hrmp_in_if, hrmp_out_if and heart_rate_measurement_parser.
`timescale 1ns / 100ps

module heart_rate_measurement_parser_tb
  import hrmp_pkg::*;
();

  localparam int ITEM_TARGET = 1150;     // bytes to push through in total
  localparam int CYCLE_LIMIT = 200_000;  // generous watchdog bound for a clean run
  localparam int REPORT_MAX  = 10;
  localparam int IDLE_PCT    = 17;
  localparam int DRAIN_WAIT  = 8;        // results pass the record queue and the output register after their byte

  typedef logic [7:0] byte_q_t[$];

  // Tracks the parse state of the notification stream and keeps the fields
  // the parser owes us, oldest first.
  class hr_field_tracker;
    logic [FLAG_W-1:0] flags;
    phase_t            phase;
    logic [POS_W-1:0]  pos;
    logic [7:0]        hold;
    logic [RR_W-1:0]   rr_cnt;
    hrmp_rec_t         due_fields[$];
    int                fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      flags  = '0;
      phase  = PH_FLAGS;
      pos    = '0;
      hold   = '0;
      rr_cnt = '0;
    endfunction

    function phase_t after_energy();
      return flags[FLAG_RR] ? PH_RR_LO : PH_SKIP;
    endfunction

    function phase_t after_rate();
      return flags[FLAG_ENERGY] ? PH_EN_LO : after_energy();
    endfunction

    // One accepted byte; queues the field it completes, or the end record.
    function void take_byte(logic [7:0] b, logic is_last);
      hrmp_rec_t r;
      bit        emit;
      emit   = 1'b0;
      r      = '0;
      r.kind = KIND_END;
      if (pos < MAX_PACKET_BYTES) begin
        pos++;
        case (phase)
          PH_FLAGS: begin
            flags = b[FLAG_W-1:0];
            phase = PH_HR_LO;
          end
          PH_HR_LO: begin
            if (flags[FLAG_HR16]) begin
              hold  = b;
              phase = PH_HR_HI;
            end else begin
              emit    = 1'b1;
              r.kind  = KIND_HEART_RATE;
              r.value = {8'h00, b};
              phase   = after_rate();
            end
          end
          PH_HR_HI: begin
            emit    = 1'b1;
            r.kind  = KIND_HEART_RATE;
            r.value = {b, hold};
            phase   = after_rate();
          end
          PH_EN_LO: begin
            hold  = b;
            phase = PH_EN_HI;
          end
          PH_EN_HI: begin
            emit    = 1'b1;
            r.kind  = KIND_ENERGY;
            r.value = {b, hold};
            phase   = after_energy();
          end
          PH_RR_LO: begin
            hold  = b;
            phase = PH_RR_HI;
          end
          PH_RR_HI: begin
            emit    = 1'b1;
            r.kind  = KIND_RR;
            r.value = {b, hold};  // raw, 1/1024 s
            r.slot  = COUNT_OUT_W'(rr_cnt);
            rr_cnt++;
            phase   = (rr_cnt >= MAX_RR_INTERVALS) ? PH_SKIP : PH_RR_LO;
          end
          default: ;
        endcase
      end
      if (!emit && !is_last) return;
      r.ignored      = is_last && (pos == 1);
      r.contact_sup  = flags[FLAG_CONTACT_SUP] && !r.ignored;
      r.contact_stat = flags[FLAG_CONTACT_SUP] && flags[FLAG_CONTACT] && !r.ignored;
      r.done         = is_last;
      r.rr_total     = COUNT_OUT_W'(rr_cnt);
      due_fields.push_back(r);
      if (is_last) clear();
    endfunction

    function string show(hrmp_rec_t r);
      return $sformatf("kind %0d value %h slot %0d sup %b det %b done %b rr %0d ign %b",
                       r.kind, r.value, r.slot, r.contact_sup, r.contact_stat, r.done,
                       r.rr_total, r.ignored);
    endfunction

    function void flag_fail(string msg);
      fails++;
      if (fails <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
    endfunction

    // One accepted result against the oldest owed field.
    function void check_field(hrmp_rec_t got);
      hrmp_rec_t exp;
      string     bad;
      if (due_fields.size() == 0) begin
        flag_fail({"result with none owed: ", show(got)});
        return;
      end
      exp = due_fields.pop_front();
      bad = "";
      if (got.kind !== exp.kind)                 bad = {bad, " field_kind"};
      if (got.value !== exp.value)               bad = {bad, " field_value"};
      if (got.slot !== exp.slot)                 bad = {bad, " rr_slot"};
      if (got.contact_sup !== exp.contact_sup)   bad = {bad, " contact_supported"};
      if (got.contact_stat !== exp.contact_stat) bad = {bad, " contact_detected"};
      if (got.done !== exp.done)                 bad = {bad, " packet_done"};
      if (got.rr_total !== exp.rr_total)         bad = {bad, " rr_total"};
      if (got.ignored !== exp.ignored)           bad = {bad, " packet_ignored"};
      if (bad != "")
        flag_fail({"mismatch on", bad, "\n  exp ", show(exp), "\n  got ", show(got)});
    endfunction

    function int owed();
      return due_fields.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   bytes_sent;
  bit   quiet;  // no idling on either side while set

  hr_field_tracker tracker;

  hrmp_in_if  meas_in();
  hrmp_out_if meas_out();

  heart_rate_measurement_parser dut (
    .clk      (clk),
    .rst      (rst),
    .meas_in  (meas_in),
    .meas_out (meas_out)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("heart_rate_measurement_parser_tb failed");
      $finish;
    end
  end

  // Result side stalls ~17% of cycles, except in the quiet stretch.
  always @(posedge clk) begin
    if (rst)
      meas_out.ready <= 1'b0;
    else
      meas_out.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: pre-edge values decide each transaction. Results are checked
  // before the byte of the same edge is noted; a byte never yields its
  // result in the cycle it is taken.
  always @(posedge clk) begin
    hrmp_rec_t got;
    if (!rst) begin
      if (meas_out.valid && meas_out.ready) begin
        got.kind         = field_kind_t'(meas_out.field_kind);
        got.value        = meas_out.field_value;
        got.slot         = meas_out.rr_slot;
        got.contact_sup  = meas_out.contact_supported;
        got.contact_stat = meas_out.contact_detected;
        got.done         = meas_out.packet_done;
        got.rr_total     = meas_out.rr_total;
        got.ignored      = meas_out.packet_ignored;
        tracker.check_field(got);
      end
      if (meas_in.valid && meas_in.ready)
        tracker.take_byte(meas_in.data_byte, meas_in.packet_end);
    end
  end

  // Presents one byte and holds it until the parser takes it. Called at a
  // rising edge; returns at the edge of the transaction.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      meas_in.valid <= 1'b0;
      @(posedge clk);
    end
    meas_in.valid      <= 1'b1;
    meas_in.data_byte  <= b;
    meas_in.packet_end <= is_last;
    @(posedge clk);
    while (!meas_in.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // Random notification. Mostly well-formed (length matches the flags),
  // the rest cut short or padded, over-long, flags-only or plain noise.
  function automatic byte_q_t make_packet();
    byte_q_t     p;
    logic [7:0]  fl;
    int          len;
    int          rr_room;
    int unsigned sel;
    sel     = $urandom_range(99);
    fl      = 8'($urandom);
    len     = 1 + (fl[FLAG_HR16] ? 2 : 1) + (fl[FLAG_ENERGY] ? 2 : 0);
    rr_room = (MAX_PACKET_BYTES - len) / 2;
    if (fl[FLAG_RR]) len += 2 * $urandom_range(rr_room, 0);
    if (sel < 65)
      ;
    else if (sel < 77)
      len = $urandom_range(1) ? len + 1 : $urandom_range(len - 1, 1);
    else if (sel < 87)
      len = $urandom_range(MAX_PACKET_BYTES + 8, MAX_PACKET_BYTES + 1);
    else if (sel < 93)
      len = 1;
    else
      len = $urandom_range(MAX_PACKET_BYTES, 1);
    p.push_back(fl);
    repeat (len - 1) p.push_back(8'($urandom));
    return p;
  endfunction

  initial begin
    byte_q_t pkt;
    tracker                 = new();
    bytes_sent              = 0;
    quiet                   = 1'b0;
    rst                    <= 1'b1;
    meas_in.valid          <= 1'b0;
    meas_in.data_byte      <= 8'h00;
    meas_in.packet_end     <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flags-only notification: end record, ignored, contact bits cleared
    pkt = {8'h1F};
    send_packet(pkt);
    // 8-bit rate of zero, contact supported and detected
    pkt = {8'h06, 8'h00};
    send_packet(pkt);
    // contact status without support reads as not detected; rate at max
    pkt = {8'h02, 8'hFF};
    send_packet(pkt);
    // every field, extreme values, then a lone trailing byte
    pkt = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h5A};
    send_packet(pkt);
    // 16-bit rate cut off after its low byte
    pkt = {8'h01, 8'h80};
    send_packet(pkt);
    // upper flag bits ignored; energy cut off after its low byte
    pkt = {8'hE8, 8'h7F, 8'hAA};
    send_packet(pkt);
    // RR flagged but none sent; the rate itself carries packet_done
    pkt = {8'h10, 8'h01};
    send_packet(pkt);

    while (bytes_sent < ITEM_TARGET) begin
      // one long stretch with no idling on either side
      quiet = (bytes_sent >= 450) && (bytes_sent < 650);
      pkt   = make_packet();
      send_packet(pkt);
    end
    quiet          = 1'b0;
    meas_in.valid <= 1'b0;

    while (tracker.owed() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tracker.fails == 0)
      $display("heart_rate_measurement_parser_tb passed");
    else
      $display("heart_rate_measurement_parser_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/hrmp_pkg.sv
sv/hrmp_in_if.sv
sv/hrmp_out_if.sv
sv/hrmp_front.sv
sv/hrmp_queue.sv
sv/hrmp_back.sv
sv/heart_rate_measurement_parser.sv
tb/heart_rate_measurement_parser_tb.sv
